// ===== design/gtg_pkg.sv =====
// Shared constants, register codes and angle helpers for the go-to-goal controller.
package gtg_pkg;

  localparam int CORDIC_ITERATIONS = 16;
  localparam int FRAC_BITS         = 16;

  localparam int ATAN_LEN     = 32;
  localparam int CORDIC_STEPS = (CORDIC_ITERATIONS < ATAN_LEN) ? CORDIC_ITERATIONS : ATAN_LEN;
  // square root takes one bit per stage; the CORDIC is padded to the same depth
  localparam int CORE_STAGES  = 32;

  localparam int CW     = 37;             // CORDIC x/y width
  localparam int ZW     = FRAC_BITS + 4;  // CORDIC angle width
  localparam int ANG_W  = 24;             // Q8.16 angle width
  localparam int SH_Q30 = 30 - FRAC_BITS;
  localparam int SH_DN  = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int SH_UP  = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

  localparam longint PI_Q30 = 64'd3373259426;
  localparam longint ATAN_Q30 [ATAN_LEN] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
    65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
    15, 8, 4, 2, 1, 0
  };

  localparam logic [1:0] REG_DIST_TOL = 2'd0;
  localparam logic [1:0] REG_ANG_TOL  = 2'd1;
  localparam logic [1:0] REG_ANG_GAIN = 2'd2;
  localparam logic [1:0] REG_LIN_GAIN = 2'd3;

  localparam logic [30:0] DIST_TOL_RST = 31'd655;
  localparam logic [30:0] ANG_TOL_RST  = 31'd3277;
  localparam logic [15:0] ANG_GAIN_RST = 16'd1024;
  localparam logic [15:0] LIN_GAIN_RST = 16'd768;

  localparam logic [1:0] MODE_TURN    = 2'd0;
  localparam logic [1:0] MODE_DRIVE   = 2'd1;
  localparam logic [1:0] MODE_ARRIVED = 2'd2;

  // Q2.30 constant rounded to FRAC_BITS
  function automatic logic signed [ZW-1:0] q30_to_frac(input longint t);
    longint r;
    r = (t + (longint'(1) <<< (SH_Q30 - 1))) >>> SH_Q30;
    return r[ZW-1:0];
  endfunction

  function automatic logic signed [ANG_W-1:0] frac_to_q16(input logic signed [ZW-1:0] z);
    logic signed [ZW+7:0] w;
    w = {{8{z[ZW-1]}}, z};
    w = (w >>> SH_DN) <<< SH_UP;
    return w[ANG_W-1:0];
  endfunction

endpackage

// ===== design/gtg_cordic.sv =====
// Pipelined CORDIC vectoring atan2, one rotation per stage up to CORDIC_STEPS; later stages pass through.
module gtg_cordic
  import gtg_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [CW-1:0] y_i,
  input  logic signed [CW-1:0] x_i,
  output logic signed [ZW-1:0] z_o
);

  localparam logic signed [ZW-1:0] PI_F = q30_to_frac(PI_Q30);

  logic signed [CW-1:0] x_w [CORE_STAGES+1];
  logic signed [CW-1:0] y_w [CORE_STAGES+1];
  logic signed [ZW-1:0] z_w [CORE_STAGES+1];

  logic signed [CW-1:0] x0_q, y0_q;
  logic signed [ZW-1:0] z0_q;

  // left half plane: rotate by pi first
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (x_i < 0) begin
        x0_q <= -x_i;
        y0_q <= -y_i;
        z0_q <= (y_i >= 0) ? PI_F : -PI_F;
      end else begin
        x0_q <= x_i;
        y0_q <= y_i;
        z0_q <= '0;
      end
    end
  end

  assign x_w[0] = x0_q;
  assign y_w[0] = y0_q;
  assign z_w[0] = z0_q;

  for (genvar i = 0; i < CORE_STAGES; i++) begin : g_step
    localparam logic signed [ZW-1:0] A = q30_to_frac(ATAN_Q30[i]);
    logic signed [CW-1:0] x_q, y_q;
    logic signed [ZW-1:0] z_q;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (i >= CORDIC_STEPS) begin
          x_q <= x_w[i];
          y_q <= y_w[i];
          z_q <= z_w[i];
        end else if (y_w[i] > 0) begin
          x_q <= x_w[i] + (y_w[i] >>> i);
          y_q <= y_w[i] - (x_w[i] >>> i);
          z_q <= z_w[i] + A;
        end else begin
          x_q <= x_w[i] - (y_w[i] >>> i);
          y_q <= y_w[i] + (x_w[i] >>> i);
          z_q <= z_w[i] - A;
        end
      end
    end

    assign x_w[i+1] = x_q;
    assign y_w[i+1] = y_q;
    assign z_w[i+1] = z_q;
  end

  assign z_o = z_w[CORE_STAGES];

endmodule

// ===== design/gtg_isqrt.sv =====
// Pipelined integer square root of a 64-bit value, one result bit per stage.
module gtg_isqrt
  import gtg_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] n_i,
  output logic [31:0] root_o
);

  logic [63:0] n_w [CORE_STAGES+1];
  logic [63:0] r_w [CORE_STAGES+1];

  assign n_w[0] = n_i;
  assign r_w[0] = '0;

  for (genvar k = 0; k < CORE_STAGES; k++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] n_q, r_q, t;

    assign t = r_w[k] + BIT;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (n_w[k] >= t) begin
          n_q <= n_w[k] - t;
          r_q <= (r_w[k] >> 1) + BIT;
        end else begin
          n_q <= n_w[k];
          r_q <= r_w[k] >> 1;
        end
      end
    end

    assign n_w[k+1] = n_q;
    assign r_w[k+1] = r_q;
  end

  assign root_o = r_w[CORE_STAGES][31:0];

endmodule

// ===== design/go_to_goal_turn_then_drive.sv =====
// Go-to-goal controller top level: stream ports, register file and pipeline.
// Throughput: one word per cycle while the output is not stalled; depth set by the 32-stage
// square root, which the two CORDIC pipelines run alongside.
// The whole pipeline advances unless the output register holds an untaken word.
// Reset clears all valid bits and loads the register defaults.
module go_to_goal_turn_then_drive
  import gtg_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // pos_x, pos_y, quat_x, quat_y, quat_z, quat_w, goal_x, goal_y
  input  logic [191:0] s_axis_tdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // linear_speed [30:0], angular_speed [62:31], zero pad
  output logic [63:0]  m_axis_tdata,
  // move_mode [1:0], saturated [2]
  output logic [2:0]   m_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int LAT    = CORE_STAGES + 7;
  localparam int HV_LEN = CORE_STAGES + 3;

  // ---------------- registers ----------------
  logic [30:0] dist_tol_q, ang_tol_q;
  logic [15:0] ang_gain_q, lin_gain_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_tol_q <= DIST_TOL_RST;
      ang_tol_q  <= ANG_TOL_RST;
      ang_gain_q <= ANG_GAIN_RST;
      lin_gain_q <= LIN_GAIN_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_DIST_TOL: dist_tol_q <= pwdata[30:0];
        REG_ANG_TOL:  ang_tol_q  <= pwdata[30:0];
        REG_ANG_GAIN: ang_gain_q <= pwdata[15:0];
        REG_LIN_GAIN: lin_gain_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_DIST_TOL: prdata = {1'b0, dist_tol_q};
      REG_ANG_TOL:  prdata = {1'b0, ang_tol_q};
      REG_ANG_GAIN: prdata = {16'd0, ang_gain_q};
      REG_LIN_GAIN: prdata = {16'd0, lin_gain_q};
      default:      prdata = '0;
    endcase
  end

  // ---------------- flow control ----------------
  logic           en;
  logic [LAT-1:0] vld_q;

  assign en            = !vld_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  // ---------------- stage 1: differences, quaternion products ----------------
  logic signed [31:0] pos_x, pos_y, goal_x, goal_y;
  logic signed [15:0] quat_x, quat_y, quat_z, quat_w;

  assign pos_x  = signed'(s_axis_tdata[31:0]);
  assign pos_y  = signed'(s_axis_tdata[63:32]);
  assign quat_x = signed'(s_axis_tdata[79:64]);
  assign quat_y = signed'(s_axis_tdata[95:80]);
  assign quat_z = signed'(s_axis_tdata[111:96]);
  assign quat_w = signed'(s_axis_tdata[127:112]);
  assign goal_x = signed'(s_axis_tdata[159:128]);
  assign goal_y = signed'(s_axis_tdata[191:160]);

  logic signed [32:0] dx1_q, dy1_q;
  logic signed [31:0] p_wz_q, p_yx_q, p_zz_q, p_yy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx1_q  <= {goal_x[31], goal_x} - {pos_x[31], pos_x};
      dy1_q  <= {goal_y[31], goal_y} - {pos_y[31], pos_y};
      p_wz_q <= quat_w * quat_z;
      p_yx_q <= quat_y * quat_x;
      p_zz_q <= quat_z * quat_z;
      p_yy_q <= quat_y * quat_y;
    end
  end

  // ---------------- stage 2: magnitudes, yaw vector ----------------
  logic [31:0] adx, ady;
  logic        halve;
  logic signed [33:0] s_sum, c_sum;

  assign adx   = dx1_q[32] ? 32'(-dx1_q) : dx1_q[31:0];
  assign ady   = dy1_q[32] ? 32'(-dy1_q) : dy1_q[31:0];
  assign halve = adx[31] || ady[31];
  assign s_sum = ({{2{p_wz_q[31]}}, p_wz_q} + {{2{p_yx_q[31]}}, p_yx_q}) <<< 1;
  assign c_sum = (34'sd1 <<< 28) -
                 (({{2{p_zz_q[31]}}, p_zz_q} + {{2{p_yy_q[31]}}, p_yy_q}) <<< 1);

  logic [30:0]        ax2_q, ay2_q;
  logic signed [33:0] s2_q, c2_q;
  logic signed [32:0] dx2_q, dy2_q;
  logic [HV_LEN-1:0]  hv_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax2_q <= halve ? adx[31:1] : adx[30:0];
      ay2_q <= halve ? ady[31:1] : ady[30:0];
      s2_q  <= s_sum;
      c2_q  <= c_sum;
      dx2_q <= dx1_q;
      dy2_q <= dy1_q;
      hv_q  <= {hv_q[HV_LEN-2:0], halve};
    end
  end

  // ---------------- stage 3: squares, CORDIC inputs ----------------
  logic [63:0]          sqa3_q, sqb3_q;
  logic signed [CW-1:0] yy3_q, yx3_q, by3_q, bx3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqa3_q <= {2'b00, 62'(ax2_q * ax2_q)};
      sqb3_q <= {2'b00, 62'(ay2_q * ay2_q)};
      yy3_q  <= {{(CW-34){s2_q[33]}}, s2_q};
      yx3_q  <= {{(CW-34){c2_q[33]}}, c2_q};
      by3_q  <= {{(CW-33){dy2_q[32]}}, dy2_q};
      bx3_q  <= {{(CW-33){dx2_q[32]}}, dx2_q};
    end
  end

  // ---------------- stage 4: sum of squares ----------------
  logic [63:0] n4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      n4_q <= sqa3_q + sqb3_q;
    end
  end

  // ---------------- stages 5..36: root and both angles ----------------
  logic [31:0]          root;
  logic signed [ZW-1:0] yaw_z, brg_z;

  gtg_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .n_i    (n4_q),
    .root_o (root)
  );

  gtg_cordic u_cordic_yaw (
    .clk_i (clk_i),
    .en_i  (en),
    .y_i   (yy3_q),
    .x_i   (yx3_q),
    .z_o   (yaw_z)
  );

  gtg_cordic u_cordic_brg (
    .clk_i (clk_i),
    .en_i  (en),
    .y_i   (by3_q),
    .x_i   (bx3_q),
    .z_o   (brg_z)
  );

  // ---------------- stage 37: distance, heading error ----------------
  logic [32:0]             dist37_q;
  logic signed [ANG_W-1:0] err37_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dist37_q <= hv_q[HV_LEN-1] ? {root, 1'b0} : {1'b0, root};
      err37_q  <= frac_to_q16(brg_z) - frac_to_q16(yaw_z);
    end
  end

  // ---------------- stage 38: decision, gain products ----------------
  logic [ANG_W-1:0] aerr;
  assign aerr = err37_q[ANG_W-1] ? ANG_W'(-err37_q) : err37_q;

  logic [1:0]               mode38_q;
  logic signed [ANG_W+16:0] angp38_q;
  logic [48:0]              linp38_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (dist37_q < {2'b00, dist_tol_q}) begin
        mode38_q <= MODE_ARRIVED;
      end else if ({{(31-ANG_W){1'b0}}, aerr} > ang_tol_q) begin
        mode38_q <= MODE_TURN;
      end else begin
        mode38_q <= MODE_DRIVE;
      end
      angp38_q <= signed'({1'b0, ang_gain_q}) * err37_q;
      linp38_q <= lin_gain_q * dist37_q;
    end
  end

  // ---------------- stage 39: clip, output register ----------------
  logic signed [ANG_W+16:0] ang_sh;
  logic [40:0]              lin_sh;
  logic                     ang_hi, ang_lo, lin_hi;

  assign ang_sh = angp38_q >>> 8;
  assign lin_sh = linp38_q[48:8];
  assign ang_hi = ang_sh > $signed((ANG_W+17)'(32'h7FFF_FFFF));
  assign ang_lo = ang_sh < -$signed((ANG_W+17)'(33'h1_0000_0000) >>> 1);
  assign lin_hi = lin_sh > 41'h0_7FFF_FFFF;

  logic [30:0] lin_q;
  logic [31:0] ang_q;
  logic [1:0]  mode_q;
  logic        sat_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      mode_q <= mode38_q;
      lin_q  <= '0;
      ang_q  <= '0;
      sat_q  <= 1'b0;
      if (mode38_q == MODE_TURN) begin
        if (ang_hi) begin
          ang_q <= 32'h7FFF_FFFF;
          sat_q <= 1'b1;
        end else if (ang_lo) begin
          ang_q <= 32'h8000_0000;
          sat_q <= 1'b1;
        end else begin
          ang_q <= ang_sh[31:0];
        end
      end else if (mode38_q == MODE_DRIVE) begin
        if (lin_hi) begin
          lin_q <= 31'h7FFF_FFFF;
          sat_q <= 1'b1;
        end else begin
          lin_q <= lin_sh[30:0];
        end
      end
    end
  end

  assign m_axis_tdata = {1'b0, ang_q, lin_q};
  assign m_axis_tuser = {sat_q, mode_q};

  // ---------------- assertions ----------------
  a_arrived_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1:0] == MODE_ARRIVED |->
      m_axis_tdata[62:0] == '0 && !m_axis_tuser[2])
    else $error("arrived word carries a speed");

  a_turn_no_lin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1:0] == MODE_TURN |-> m_axis_tdata[30:0] == '0)
    else $error("turning word carries a linear speed");

  a_drive_no_ang : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1:0] == MODE_DRIVE |-> m_axis_tdata[62:31] == '0)
    else $error("driving word carries an angular speed");

  a_stall_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while pipeline is stalled");

endmodule

// ===== test/go_to_goal_turn_then_drive_chk.sv =====
// Checker for the go-to-goal controller: tracks registers, predicts each result word and compares.
module go_to_goal_turn_then_drive_chk
  import gtg_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [191:0] s_axis_tdata,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [63:0]  m_axis_tdata,
  input  logic [2:0]   m_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic         pready,
  output int           errors_o,
  output int           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [30:0] lin;
    logic [31:0] ang;
    logic [1:0]  mode;
    logic        sat;
  } cmd_t;

  cmd_t        cmd_q[$];
  logic [30:0] dist_tol;
  logic [30:0] ang_tol;
  logic [15:0] ang_gain;
  logic [15:0] lin_gain;
  int          errors;

  assign errors_o  = errors;
  assign pending_o = cmd_q.size();

  function automatic longint atan_frac(longint t);
    return (t + (longint'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
  endfunction

  function automatic longint vec_angle(longint y, longint x);
    longint z, xs, ys, a;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? atan_frac(PI_Q30) : -atan_frac(PI_Q30);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_ITERATIONS && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      a  = atan_frac(ATAN_Q30[i]);
      if (y > 0) begin
        x = x + ys; y = y - xs; z = z + a;
      end else begin
        x = x - ys; y = y + xs; z = z - a;
      end
    end
    if (FRAC_BITS >= 16) return z >>> (FRAC_BITS - 16);
    return z <<< (16 - FRAC_BITS);
  endfunction

  function automatic logic [63:0] int_root(logic [63:0] n);
    logic [63:0] res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic cmd_t steer(logic [191:0] d);
    longint px, py, gx, gy, qx, qy, qz, qw, dx, dy, s, c, err, aerr, ang;
    logic [63:0] ax, ay, rng, lin;
    logic halved;
    cmd_t r;
    px = longint'($signed(d[31:0]));
    py = longint'($signed(d[63:32]));
    qx = longint'($signed(d[79:64]));
    qy = longint'($signed(d[95:80]));
    qz = longint'($signed(d[111:96]));
    qw = longint'($signed(d[127:112]));
    gx = longint'($signed(d[159:128]));
    gy = longint'($signed(d[191:160]));
    dx = gx - px;
    dy = gy - py;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    halved = 0;
    // far goal: halve both legs, double the root
    if (ax >= 64'h8000_0000 || ay >= 64'h8000_0000) begin
      ax = ax >> 1; ay = ay >> 1; halved = 1;
    end
    rng = int_root(ax * ax + ay * ay);
    if (halved) rng = rng << 1;
    r = '0;
    if (rng < dist_tol) begin
      r.mode = MODE_ARRIVED;
    end else begin
      s    = 2 * (qw * qz + qy * qx);
      c    = (longint'(1) <<< 28) - 2 * (qz * qz + qy * qy);
      err  = vec_angle(dy, dx) - vec_angle(s, c);
      aerr = (err < 0) ? -err : err;
      if (aerr > longint'(ang_tol)) begin
        r.mode = MODE_TURN;
        ang = (longint'(ang_gain) * err) >>> 8;
        if (ang > 64'sd2147483647) begin ang = 64'sd2147483647; r.sat = 1; end
        if (ang < -64'sd2147483648) begin ang = -64'sd2147483648; r.sat = 1; end
        r.ang = ang[31:0];
      end else begin
        r.mode = MODE_DRIVE;
        lin = (64'(lin_gain) * rng) >> 8;
        if (lin > 64'h7FFF_FFFF) begin lin = 64'h7FFF_FFFF; r.sat = 1; end
        r.lin = lin[30:0];
      end
    end
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cmd_t w;
    if (!rst_ni) begin
      dist_tol <= DIST_TOL_RST;
      ang_tol  <= ANG_TOL_RST;
      ang_gain <= ANG_GAIN_RST;
      lin_gain <= LIN_GAIN_RST;
      errors   = 0;
      cmd_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_DIST_TOL: dist_tol <= pwdata[30:0];
          REG_ANG_TOL:  ang_tol  <= pwdata[30:0];
          REG_ANG_GAIN: ang_gain <= pwdata[15:0];
          REG_LIN_GAIN: lin_gain <= pwdata[15:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) cmd_q.push_back(steer(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (cmd_q.size() == 0) begin
          report("unexpected word", m_axis_tdata[31:0], '0);
        end else begin
          w = cmd_q.pop_front();
          if (m_axis_tdata[30:0] !== w.lin)
            report("linear_speed", {1'b0, m_axis_tdata[30:0]}, {1'b0, w.lin});
          if (m_axis_tdata[62:31] !== w.ang)
            report("angular_speed", m_axis_tdata[62:31], w.ang);
          if (m_axis_tdata[63] !== 1'b0) report("pad", m_axis_tdata[63], 0);
          if (m_axis_tuser[1:0] !== w.mode) report("move_mode", m_axis_tuser[1:0], w.mode);
          if (m_axis_tuser[2] !== w.sat) report("saturated", m_axis_tuser[2], w.sat);
        end
      end
    end
  end

endmodule

// ===== test/go_to_goal_turn_then_drive_tb.sv =====
// Testbench top for the go-to-goal controller: clock, reset, register phases and pose stimulus.
module go_to_goal_turn_then_drive_tb
  import gtg_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic [191:0] s_axis_tdata = '0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [63:0]  m_axis_tdata;
  logic [2:0]   m_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic         psel = 0, penable = 0, pwrite = 0;
  logic [3:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;
  int           errors, pending;
  int           send_idle = 0, recv_stall = 0;

  go_to_goal_turn_then_drive dut (.*);
  go_to_goal_turn_then_drive_chk chk (.*, .errors_o(errors), .pending_o(pending));

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99) >= recv_stall);

  function automatic logic [191:0] pose(logic [31:0] px, logic [31:0] py, logic [15:0] qx,
      logic [15:0] qy, logic [15:0] qz, logic [15:0] qw, logic [31:0] gx, logic [31:0] gy);
    return {gy, gx, qw, qz, qy, qx, py, px};
  endfunction

  function automatic logic [15:0] rand_quat();
    return 16'($signed($urandom_range(32768)) - 16384);
  endfunction

  function automatic logic [191:0] rand_pose();
    logic [31:0] px, py, gx, gy;
    int kind;
    kind = $urandom_range(9);
    px = $urandom; py = $urandom; gx = $urandom; gy = $urandom;
    if (kind <= 3) begin
      // near the goal: arrival and tolerance edges
      px = 32'($signed(px) >>> 10);
      py = 32'($signed(py) >>> 10);
      gx = px + 32'($signed($urandom_range(4000)) - 2000);
      gy = py + 32'($signed($urandom_range(4000)) - 2000);
    end else if (kind <= 5) begin
      // heading along +x toward a goal on the x axis: drives
      gy = py;
      gx = px + ($urandom >> $urandom_range(1, 20));
      return pose(px, py, 0, 0, 0, (kind == 4) ? 16'sd16384 : 16'd0, gx, gy);
    end else if (kind >= 7) begin
      px = 32'($signed(px) >>> 8); py = 32'($signed(py) >>> 8);
      gx = 32'($signed(gx) >>> 8); gy = 32'($signed(gy) >>> 8);
    end
    return pose(px, py, rand_quat(), rand_quat(), rand_quat(), rand_quat(), gx, gy);
  endfunction

  function automatic logic [191:0] corner_pose(int k);
    case (k)
      0:  return pose(0, 0, 0, 0, 0, 16'sd16384, 0, 0);
      1:  return pose(32'h8000_0000, 32'h8000_0000, 0, 0, 0, 16'sd16384,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF);
      2:  return pose(32'h7FFF_FFFF, 0, 0, 0, 0, 16'sd16384, 32'h8000_0000, 0);
      3:  return pose(0, 32'h8000_0000, 0, 0, 0, 0, 0, 32'h7FFF_FFFF);
      4:  return pose(0, 0, 0, 0, 0, 16'sd16384, 655, 0);
      5:  return pose(0, 0, 0, 0, 0, 16'sd16384, 654, 0);
      6:  return pose(0, 0, 0, 16'sd8192, 16'sd8192, 0, 0, 0);
      7:  return pose(0, 0, 0, 16'sd8192, 16'sd8192, 0, 32'h10000, 32'h10000);
      8:  return pose(0, 0, 16'hC000, 16'hC000, 16'hC000, 16'hC000, 32'hFFFF_0000, 0);
      9:  return pose(0, 0, 16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 0, 32'hFFFF_0000);
      10: return pose(0, 0, 0, 0, 16'sd16384, 0, 32'hFFF0_0000, 0);
      11: return pose(0, 0, 0, 0, 16'hC000, 16'sd16384, 32'hFFF0_0000, 1);
      12: return pose(0, 0, 0, 0, 16'sd11585, 16'sd11585, 0, 32'h0100_0000);
      13: return pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                      32'h8000_0000, 32'h8000_0000);
      14: return pose(0, 0, 0, 0, 0, 16'sd16384, 32'h7FFF_FFFF, 0);
      default: return pose(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                           16'hFFFF, 32'hFFFF_FFFF, 32'h0);
    endcase
  endfunction

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic send_word(logic [191:0] d);
    if ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle);
    end
    s_axis_tdata  <= d;
    s_axis_tvalid <= 1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  initial begin
    #5_000_000;
    $display("[go_to_goal_turn_then_drive] ERROR");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    repeat (4) @(posedge clk_i);
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: ;  // reset values
        1: begin
          reg_write(REG_DIST_TOL, 0); reg_write(REG_ANG_TOL, 0);
          reg_write(REG_ANG_GAIN, 0); reg_write(REG_LIN_GAIN, 0);
        end
        2: begin
          reg_write(REG_DIST_TOL, 32'h7FFF_FFFF); reg_write(REG_ANG_TOL, 32'hFFFF_FFFF);
          reg_write(REG_ANG_GAIN, 32'hFFFF); reg_write(REG_LIN_GAIN, 32'hFFFF_FFFF);
        end
        3: begin
          reg_write(REG_DIST_TOL, 655); reg_write(REG_ANG_TOL, 32'h7FFF_FFFF);
          reg_write(REG_ANG_GAIN, 32'hFFFF); reg_write(REG_LIN_GAIN, 32'hFFFF);
        end
        default: begin
          reg_write(REG_DIST_TOL, $urandom_range(100000));
          reg_write(REG_ANG_TOL, $urandom_range(400000));
          reg_write(REG_ANG_GAIN, $urandom_range(65535));
          reg_write(REG_LIN_GAIN, $urandom_range(65535));
        end
      endcase
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 85; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 85; end
        default: begin send_idle = 37; recv_stall = 37; end
      endcase
      if (ph < 2)
        for (int k = 0; k < 16; k++) send_word(corner_pose(k));
      for (int n = 0; n < 210; n++) send_word(rand_pose());
      drain();
    end
    if (errors == 0)
      $display("[go_to_goal_turn_then_drive] OK");
    else
      $display("[go_to_goal_turn_then_drive] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
design/gtg_pkg.sv
design/gtg_cordic.sv
design/gtg_isqrt.sv
design/go_to_goal_turn_then_drive.sv
test/go_to_goal_turn_then_drive_chk.sv
test/go_to_goal_turn_then_drive_tb.sv
